// ----- hw/rtl/sfr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stream find-and-replace package
// Shared constants, register indexes, state encoding and the control and
// status bundles that pass between the controller and the byte cell chain.
// ----------------------------------------------------------------------------
package sfr_pkg;

    // Longest pattern and replacement, in bytes.
    localparam int MAX_PATTERN     = 8;
    localparam int MAX_REPLACEMENT = 8;

    // Widths that follow from the sizes above.
    localparam int CNT_W  = 4;   // holds 0 .. MAX_PATTERN
    localparam int IDX_W  = 3;   // addresses one cell or one replacement byte
    localparam int BYTE_W = 8;
    localparam int WORD_W = 64;  // widest configuration register
    localparam int CFG_IDX_W = 2;

    // Byte sent at the end of every line.
    localparam logic [BYTE_W-1:0] NEWLINE = 8'd10;

    // Input word kinds carried in tuser.
    localparam logic OP_DATA = 1'b0;
    localparam logic OP_EOL  = 1'b1;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LENGTH     = 2'd0,
        REG_PATTERN_BYTES      = 2'd1,
        REG_REPLACEMENT_LENGTH = 2'd2,
        REG_REPLACEMENT_BYTES  = 2'd3
    } cfg_reg_t;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,    // waiting for an input word
        S_EVAL,    // new byte appended, decide between match and realign
        S_DROP,    // send the front byte until the rest is a pattern prefix
        S_REPL,    // send the replacement
        S_FLUSH    // end of line: send buffered bytes, then a newline
    } state_t;

    // Commands from the controller to the cell chain.
    typedef struct packed {
        logic                   shift;      // every cell takes its right neighbor
        logic [MAX_PATTERN-1:0] load_mask;  // one-hot cell that takes load_byte
        logic [BYTE_W-1:0]      load_byte;
    } chain_ctrl_t;

    // Per-cell command derived from the chain command.
    typedef struct packed {
        logic              shift;
        logic              load;
        logic [BYTE_W-1:0] load_byte;
    } cell_ctrl_t;

    // Status gathered from the cell chain.
    typedef struct packed {
        logic [MAX_PATTERN-1:0] match;       // cell i equals pattern byte i
        logic [MAX_PATTERN-1:0] match_prev;  // cell i equals pattern byte i-1
        logic [BYTE_W-1:0]      head;        // byte held by cell 0
    } chain_stat_t;

endpackage

// ----- hw/rtl/sfr_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stream find-and-replace byte cell
// Holds one buffered byte, compares it against its own pattern byte and the
// one before it, and passes the byte to its left neighbor on a shift.
// ----------------------------------------------------------------------------
module sfr_cell
    import sfr_pkg::*;
(
    input  logic              aclk,
    input  cell_ctrl_t        ctrl,
    input  logic [BYTE_W-1:0] shift_in,       // byte of the right neighbor
    input  logic [BYTE_W-1:0] pat_byte,       // pattern byte at this position
    input  logic [BYTE_W-1:0] pat_prev_byte,  // pattern byte one position lower
    output logic [BYTE_W-1:0] byte_out,
    output logic              match,
    output logic              match_prev
);

    logic [BYTE_W-1:0] byte_reg;
    logic [BYTE_W-1:0] byte_next;

    // A load writes the new byte; a shift takes the neighbor's byte.
    always_comb begin
        byte_next = byte_reg;
        if (ctrl.load) begin
            byte_next = ctrl.load_byte;
        end else if (ctrl.shift) begin
            byte_next = shift_in;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
    end

    // Compare for the buffer as it stands and as it will be after one shift.
    assign byte_out   = byte_reg;
    assign match      = (byte_reg == pat_byte);
    assign match_prev = (byte_reg == pat_prev_byte);

endmodule

// ----- hw/rtl/sfr_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stream find-and-replace controller
// Keeps the fill count of the cell chain, decides between a full match and
// realignment, and sequences the output words one per cycle while m_tready is high.
// ----------------------------------------------------------------------------
module sfr_ctrl
    import sfr_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // Input stream
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                s_opcode,
    input  logic [BYTE_W-1:0]   s_byte,
    // Output stream
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [BYTE_W-1:0]   m_byte,
    output logic                m_last,
    // Saturated configuration
    input  logic [CNT_W-1:0]    plen,
    input  logic [CNT_W-1:0]    rlen,
    input  logic [WORD_W-1:0]   rep_bytes,
    // Cell chain
    output chain_ctrl_t         chain_ctrl,
    input  chain_stat_t         chain_stat
);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] rep_idx_reg, rep_idx_next;

    logic             prefix;        // buffer is a prefix of the pattern
    logic             prefix_shift;  // buffer minus its front byte is a prefix
    logic             full_match;
    logic             drop_last;
    logic             repl_last;
    logic [IDX_W-1:0] load_pos;
    logic [CNT_W-1:0] count_dec;

    // Prefix checks over the cells that are in use.
    always_comb begin
        logic all_ok;
        logic shift_ok;
        all_ok   = 1'b1;
        shift_ok = 1'b1;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if (CNT_W'(i) < count_reg && !chain_stat.match[i]) begin
                all_ok = 1'b0;
            end
            if (i >= 1 && CNT_W'(i) < count_reg && !chain_stat.match_prev[i]) begin
                shift_ok = 1'b0;
            end
        end
        count_dec    = count_reg - CNT_W'(1);
        prefix       = all_ok && (count_reg <= plen);
        prefix_shift = shift_ok && (count_dec <= plen);
    end

    assign full_match = (plen != '0) && (count_reg == plen) && prefix;
    // The front byte just sent is the last one when the rest is a prefix.
    assign drop_last  = (count_reg == CNT_W'(1)) || ((plen != '0) && prefix_shift);
    assign repl_last  = ({1'b0, rep_idx_reg} == (rlen - CNT_W'(1)));
    // A full buffer overwrites its last byte.
    assign load_pos   = (count_reg > CNT_W'(MAX_PATTERN - 1)) ?
                        IDX_W'(MAX_PATTERN - 1) : count_reg[IDX_W-1:0];

    // State register and counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            rep_idx_reg <= '0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            rep_idx_reg <= rep_idx_next;
        end
    end

    // Next state and stream outputs.
    always_comb begin
        state_next           = state_reg;
        count_next           = count_reg;
        rep_idx_next         = rep_idx_reg;
        s_tready             = 1'b0;
        m_tvalid             = 1'b0;
        m_byte               = chain_stat.head;
        m_last               = 1'b0;
        chain_ctrl.shift     = 1'b0;
        chain_ctrl.load_mask = '0;
        chain_ctrl.load_byte = s_byte;

        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_opcode == OP_EOL) begin
                        state_next = S_FLUSH;
                    end else begin
                        chain_ctrl.load_mask = MAX_PATTERN'(1) << load_pos;
                        count_next = {1'b0, load_pos} + CNT_W'(1);
                        state_next = S_EVAL;
                    end
                end
            end

            S_EVAL: begin
                if (full_match) begin
                    count_next   = '0;
                    rep_idx_next = '0;
                    state_next   = (rlen == '0) ? S_IDLE : S_REPL;
                end else if (count_reg != '0 && (plen == '0 || !prefix)) begin
                    state_next = S_DROP;
                end else begin
                    state_next = S_IDLE;
                end
            end

            S_DROP: begin
                m_tvalid = 1'b1;
                m_last   = drop_last;
                if (m_tready) begin
                    chain_ctrl.shift = 1'b1;
                    count_next       = count_dec;
                    if (drop_last) begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_REPL: begin
                m_tvalid = 1'b1;
                m_byte   = rep_bytes[{rep_idx_reg, 3'b000} +: BYTE_W];
                m_last   = repl_last;
                if (m_tready) begin
                    rep_idx_next = rep_idx_reg + IDX_W'(1);
                    if (repl_last) begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_FLUSH: begin
                m_tvalid = 1'b1;
                if (count_reg == '0) begin
                    m_byte = NEWLINE;
                    m_last = 1'b1;
                end
                if (m_tready) begin
                    if (count_reg == '0) begin
                        state_next = S_IDLE;
                    end else begin
                        chain_ctrl.shift = 1'b1;
                        count_next       = count_dec;
                    end
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // The buffer never holds more bytes than there are cells.
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_PATTERN))
        else $error("fill count above cell count");

    // Input and output never move in the same cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input accepted while output pending");

    // The final word of a run returns the controller to idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_last) |=> (state_reg == S_IDLE))
        else $error("controller busy after last word");

    // A replacement is only sent with an empty buffer.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_REPL) |-> (count_reg == '0))
        else $error("replacement with buffered bytes");

    // A data word always leaves at least one byte in the buffer to evaluate.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_opcode == OP_DATA) |=>
        (state_reg == S_EVAL && count_reg != '0))
        else $error("data word not buffered");

endmodule

// ----- hw/rtl/stream_find_replace_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stream find-and-replace top level
// Replaces each leftmost, non-overlapping occurrence of a pattern of up to
// eight bytes by a replacement of up to eight bytes, line by line.
// ----------------------------------------------------------------------------
// The block takes one word at a time. It accepts a data word, evaluates it,
// then sends each output word that it causes (zero to eight); an end-of-line
// word causes each buffered byte to be sent, then a newline. The controller
// works on one input word at a time, and the single output port sends one
// word a cycle while m_tready is high. Partial matches are held in a chain
// of eight byte cells that shift toward the front as bytes are sent.
// Configuration is written through cfg_wr_en, cfg_index and cfg_data; the
// user must do so only while the block is idle, which the block itself does
// not enforce; lengths above eight are treated as eight.
// ----------------------------------------------------------------------------
module stream_find_replace_top
    import sfr_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // Configuration write port
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data,
    // Input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [BYTE_W-1:0]    s_tdata,   // [7:0] data_byte
    input  logic                 s_tuser,   // [0] opcode
    // Output stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [BYTE_W-1:0]    m_tdata,   // [7:0] out_byte
    output logic                 m_tlast
);

    logic [CNT_W-1:0]  pat_len_reg;
    logic [WORD_W-1:0] pat_bytes_reg;
    logic [CNT_W-1:0]  rep_len_reg;
    logic [WORD_W-1:0] rep_bytes_reg;

    logic [CNT_W-1:0]  plen;
    logic [CNT_W-1:0]  rlen;

    chain_ctrl_t       chain_ctrl;
    chain_stat_t       chain_stat;
    logic [BYTE_W-1:0] cell_byte [MAX_PATTERN];

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_len_reg   <= CNT_W'(1);
            pat_bytes_reg <= '0;
            rep_len_reg   <= '0;
            rep_bytes_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_PATTERN_LENGTH:     pat_len_reg   <= cfg_data[CNT_W-1:0];
                REG_PATTERN_BYTES:      pat_bytes_reg <= cfg_data;
                REG_REPLACEMENT_LENGTH: rep_len_reg   <= cfg_data[CNT_W-1:0];
                REG_REPLACEMENT_BYTES:  rep_bytes_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Lengths saturate at the cell count.
    assign plen = (pat_len_reg > CNT_W'(MAX_PATTERN)) ? CNT_W'(MAX_PATTERN) : pat_len_reg;
    assign rlen = (rep_len_reg > CNT_W'(MAX_REPLACEMENT)) ?
                  CNT_W'(MAX_REPLACEMENT) : rep_len_reg;

    // Chain of byte cells; cell 0 is the front of the buffer.
    for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
        cell_ctrl_t        cctrl;
        logic [BYTE_W-1:0] shift_in;
        logic [BYTE_W-1:0] pat_prev;

        assign cctrl.shift     = chain_ctrl.shift;
        assign cctrl.load      = chain_ctrl.load_mask[i];
        assign cctrl.load_byte = chain_ctrl.load_byte;

        if (i == MAX_PATTERN - 1) begin : g_tail
            assign shift_in = '0;
        end else begin : g_body
            assign shift_in = cell_byte[i+1];
        end

        if (i == 0) begin : g_front
            assign pat_prev = pat_bytes_reg[BYTE_W-1:0];
        end else begin : g_rest
            assign pat_prev = pat_bytes_reg[(i-1)*BYTE_W +: BYTE_W];
        end

        sfr_cell u_cell (
            .aclk          (aclk),
            .ctrl          (cctrl),
            .shift_in      (shift_in),
            .pat_byte      (pat_bytes_reg[i*BYTE_W +: BYTE_W]),
            .pat_prev_byte (pat_prev),
            .byte_out      (cell_byte[i]),
            .match         (chain_stat.match[i]),
            .match_prev    (chain_stat.match_prev[i])
        );
    end

    assign chain_stat.head = cell_byte[0];

    // Sequencer for matching and output.
    sfr_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_opcode   (s_tuser),
        .s_byte     (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_byte     (m_tdata),
        .m_last     (m_tlast),
        .plen       (plen),
        .rlen       (rlen),
        .rep_bytes  (rep_bytes_reg),
        .chain_ctrl (chain_ctrl),
        .chain_stat (chain_stat)
    );

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stream find-and-replace testbench
// Drives lines of bytes into the block and checks each rewritten output word.
// A shadow copy of the match buffer and registers predicts every output word.
// Directed tests cover reset values, realignment, saturated lengths, empty
// patterns and replacements, and register changes in the middle of a line.
// Random traffic then runs under several idle and stall patterns.
// ----------------------------------------------------------------------------
module testbench
    import sfr_pkg::*;
;

    localparam int TIMEOUT_NS   = 1_000_000;
    localparam int DRAIN_CYCLES = 20;
    localparam int REPORT_LIMIT = 10;

    // One predicted output word.
    typedef struct packed {
        logic [BYTE_W-1:0] ch;
        logic              last;
    } out_word_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [WORD_W-1:0]    cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [BYTE_W-1:0]    s_tdata   = '0;   // [7:0] data_byte
    logic                 s_tuser   = 1'b0; // [0] opcode
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [BYTE_W-1:0]    m_tdata;          // [7:0] out_byte
    logic                 m_tlast;          // last_of_run

    // Shadow registers and match buffer.
    logic [3:0]        cfg_pat_len = 4'd1;
    logic [WORD_W-1:0] cfg_pat     = '0;
    logic [3:0]        cfg_rep_len = 4'd0;
    logic [WORD_W-1:0] cfg_rep     = '0;
    logic [BYTE_W-1:0] held_bytes [MAX_PATTERN];
    int unsigned       held_count  = 0;

    out_word_t rewritten_q [$];
    out_word_t want_word;

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int mismatch_count = 0;
    int words_in       = 0;
    int words_out      = 0;
    int config_count   = 0;

    stream_find_replace_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #1 aclk = ~aclk;

    // True when the held bytes are a prefix of the pattern.
    function automatic bit held_is_prefix(input int unsigned plen);
        if (held_count > plen)
            return 1'b0;
        for (int i = 0; i < held_count; i++) begin
            if (held_bytes[i] != cfg_pat[8*i +: 8])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Work out the output words that one accepted input word causes.
    function automatic void rewrite_word(input logic op, input logic [BYTE_W-1:0] data);
        logic [BYTE_W-1:0] outs [16];
        int                n = 0;
        int unsigned       plen;
        int unsigned       rlen;
        plen = (cfg_pat_len > 4'd8) ? 8 : cfg_pat_len;
        rlen = (cfg_rep_len > 4'd8) ? 8 : cfg_rep_len;
        if (op == OP_EOL) begin
            for (int i = 0; i < held_count; i++) begin
                outs[n] = held_bytes[i];
                n++;
            end
            held_count = 0;
            outs[n] = NEWLINE;
            n++;
        end else begin
            if (held_count > MAX_PATTERN - 1)
                held_count = MAX_PATTERN - 1;
            held_bytes[held_count] = data;
            held_count++;
            if (plen != 0 && held_count == plen && held_is_prefix(plen)) begin
                for (int i = 0; i < rlen; i++) begin
                    outs[n] = cfg_rep[8*i +: 8];
                    n++;
                end
                held_count = 0;
            end else begin
                // Drop bytes from the front until a pattern prefix remains.
                while (held_count > 0 && (plen == 0 || !held_is_prefix(plen))) begin
                    outs[n] = held_bytes[0];
                    n++;
                    for (int j = 0; j + 1 < held_count; j++)
                        held_bytes[j] = held_bytes[j + 1];
                    held_count--;
                end
            end
        end
        for (int i = 0; i < n; i++)
            rewritten_q.push_back('{ch: outs[i], last: (i == n - 1)});
    endfunction

    function automatic void note_error(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("ERROR at %0t ns: %s", $time, msg);
    endfunction

    // Output side: random stalls, and each accepted word is checked in order.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
        if (aresetn && m_tvalid && m_tready) begin
            words_out++;
            if (rewritten_q.size() == 0) begin
                note_error($sformatf("unexpected word: byte %h last %b", m_tdata, m_tlast));
            end else begin
                want_word = rewritten_q.pop_front();
                if (m_tdata !== want_word.ch || m_tlast !== want_word.last)
                    note_error($sformatf("expected byte %h last %b, got byte %h last %b",
                                         want_word.ch, want_word.last, m_tdata, m_tlast));
            end
        end
    end

    // Send one input word; called at a rising edge, returns at its acceptance.
    task automatic send_word(input logic op, input logic [BYTE_W-1:0] data);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom);
            s_tuser  <= 1'($urandom);
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= op;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        rewrite_word(op, data);
        words_in++;
    endtask

    // Wait until every predicted word has left, then let the block settle.
    task automatic drain_block();
        s_tvalid <= 1'b0;
        while (rewritten_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic put_reg(input cfg_reg_t idx, input logic [WORD_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
    endtask

    // Write all four registers back to back; the block must be idle.
    task automatic program_registers(input logic [3:0] plen, input logic [WORD_W-1:0] pat,
                                     input logic [3:0] rlen, input logic [WORD_W-1:0] rep);
        put_reg(REG_PATTERN_LENGTH, {60'd0, plen});
        put_reg(REG_PATTERN_BYTES, pat);
        put_reg(REG_REPLACEMENT_LENGTH, {60'd0, rlen});
        put_reg(REG_REPLACEMENT_BYTES, rep);
        cfg_wr_en   <= 1'b0;
        cfg_pat_len  = plen;
        cfg_pat      = pat;
        cfg_rep_len  = rlen;
        cfg_rep      = rep;
        config_count++;
    endtask

    // Reset values: a one-byte zero pattern with an empty replacement deletes zeros.
    task automatic test_reset_config();
        send_word(OP_DATA, 8'h00);
        send_word(OP_DATA, 8'hFF);
        send_word(OP_EOL, 8'hFF);
    endtask

    // A broken partial match drops its front byte, then the match completes.
    task automatic test_realign_and_match();
        drain_block();
        program_registers(4'd3, 64'h62_61_61, 4'd2, 64'h59_58);
        send_word(OP_DATA, 8'h61);
        send_word(OP_DATA, 8'h61);
        send_word(OP_DATA, 8'h61);
        send_word(OP_DATA, 8'h62);
        send_word(OP_EOL, 8'h00);
    endtask

    // Lengths above eight are treated as eight on both registers.
    task automatic test_saturated_lengths();
        drain_block();
        program_registers(4'hF, 64'h00FF00FF_7F80FE01, 4'hC, 64'hFF000102_03040580);
        for (int i = 0; i < 8; i++)
            send_word(OP_DATA, cfg_pat[8*i +: 8]);
    endtask

    // Bytes held from a partial match survive a switch to an empty pattern.
    task automatic test_midline_zero_pattern();
        for (int i = 0; i < 3; i++)
            send_word(OP_DATA, cfg_pat[8*i +: 8]);
        drain_block();
        program_registers(4'd0, cfg_pat, 4'd0, 64'd0);
        send_word(OP_DATA, 8'h55);
        send_word(OP_EOL, 8'h01);
    endtask

    // An empty replacement deletes each match; the line end flushes the rest.
    task automatic test_empty_replacement();
        drain_block();
        program_registers(4'd2, 64'h62_61, 4'd0, 64'hFFFFFFFF_FFFFFFFF);
        send_word(OP_DATA, 8'h61);
        send_word(OP_DATA, 8'h62);
        send_word(OP_DATA, 8'h61);
        send_word(OP_EOL, 8'h80);
    endtask

    // Random lines built mostly from pattern bytes, under one idle and one stall pattern.
    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int n_words);
        logic [BYTE_W-1:0] alphabet [3];
        logic [3:0]        plen;
        logic [3:0]        rlen;
        logic [WORD_W-1:0] pat;
        int                sent;
        int                pick;
        int                eff;
        int                k;
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        // Two register settings per phase, changed without ending the line.
        for (int seg = 0; seg < 2; seg++) begin
            drain_block();
            for (int i = 0; i < 3; i++)
                alphabet[i] = 8'($urandom);
            pick = $urandom_range(9);
            case (pick)
                0:       plen = 4'd0;
                1:       plen = 4'd8;
                2:       plen = 4'($urandom_range(15, 9));
                default: plen = 4'($urandom_range(4, 1));
            endcase
            pick = $urandom_range(9);
            case (pick)
                0:       rlen = 4'd0;
                1:       rlen = 4'd8;
                2:       rlen = 4'($urandom_range(15, 9));
                default: rlen = 4'($urandom_range(5, 1));
            endcase
            for (int i = 0; i < 8; i++)
                pat[8*i +: 8] = alphabet[$urandom_range(2)];
            program_registers(plen, pat, rlen, {$urandom, $urandom});
            eff = (plen > 4'd8) ? 8 : int'(plen);
            if (eff == 0)
                eff = 1;
            sent = 0;
            while (sent < n_words / 2) begin
                pick = $urandom_range(99);
                if (pick < 8) begin
                    send_word(OP_EOL, 8'($urandom));
                    sent++;
                end else if (pick < 25) begin
                    // Whole pattern, or a prefix of it.
                    k = eff;
                    if ($urandom_range(2) == 0)
                        k = $urandom_range(eff, 1);
                    for (int i = 0; i < k; i++)
                        send_word(OP_DATA, pat[8*i +: 8]);
                    sent += k;
                end else if (pick < 90) begin
                    send_word(OP_DATA, alphabet[$urandom_range(2)]);
                    sent++;
                end else begin
                    send_word(OP_DATA, 8'($urandom));
                    sent++;
                end
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        src_idle_pct   = 25;
        sink_stall_pct = 25;
        test_reset_config();
        test_realign_and_match();
        test_saturated_lengths();
        test_midline_zero_pattern();
        test_empty_replacement();

        test_random_traffic(0, 0, 34);
        test_random_traffic(81, 0, 34);
        test_random_traffic(0, 81, 34);
        test_random_traffic(10, 10, 34);

        drain_block();
        $display("Sent %0d input words under %0d register settings and checked %0d output words,",
                 words_in, config_count, words_out);
        $display("with idle input and stalled output phases; %0d mismatches.", mismatch_count);
        if (mismatch_count == 0 && rewritten_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Run limit.
    initial begin
        #TIMEOUT_NS;
        $display("Timed out with %0d output words still expected.", rewritten_q.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/sfr_pkg.sv
hw/rtl/sfr_cell.sv
hw/rtl/sfr_ctrl.sv
hw/rtl/stream_find_replace_top.sv
tb/testbench.sv
